@@ design/tdc_block_word_unpacker_unit_assert.svh @@
// Assertion macros shared by the unpacker modules.
`ifndef TDC_BLOCK_WORD_UNPACKER_UNIT_ASSERT_SVH
`define TDC_BLOCK_WORD_UNPACKER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TDC_BWU_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define TDC_BWU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/tdc_bwu_pkg.sv @@
// ----------------------------------------------------------------------------
// tdc_bwu_pkg
// Types and codes shared by the readout word unpacker modules.
// ----------------------------------------------------------------------------
package tdc_bwu_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Word type, bits 26..25 of the readout word
   localparam logic [1:0] WT_BLOCK_HDR = 2'b00;
   localparam logic [1:0] WT_CONV_HDR  = 2'b01;
   localparam logic [1:0] WT_TRAILER   = 2'b10;

   // Result kinds
   localparam logic [1:0] KIND_HIT        = 2'd0;
   localparam logic [1:0] KIND_OK         = 2'd1;
   localparam logic [1:0] KIND_TAG_ERR    = 2'd2;
   localparam logic [1:0] KIND_NO_TRAILER = 2'd3;

   localparam logic [11:0] VALUE_OVERFLOW = 12'hfff;

   typedef struct packed {
      logic       is_zero;
      logic [1:0] wtype;
      logic       board_bit;
   } word_class_type;

   typedef struct packed {
      logic [31:0]    word;
      logic [7:0]     trig_tag;
      logic           sub_start;
      word_class_type cls;
   } entry_type;

endpackage

@@ design/tdc_bwu_front.sv @@
// ----------------------------------------------------------------------------
// tdc_bwu_front
// Accepts requests, classifies each word and queues it for the parser.
// ----------------------------------------------------------------------------
`include "tdc_block_word_unpacker_unit_assert.svh"

module tdc_bwu_front
   import tdc_bwu_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_word,
   input  logic [7:0]  req_trig_tag,
   input  logic        req_sub_start,
   output logic        q_valid,
   output entry_type   q_entry,
   input  logic        q_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 push, pop;
   entry_type            entry_in;

   always_comb begin
      entry_in.word          = req_word;
      entry_in.trig_tag      = req_trig_tag;
      entry_in.sub_start     = req_sub_start;
      entry_in.cls.is_zero   = (req_word == 32'd0);
      entry_in.cls.wtype     = req_word[26:25];
      entry_in.cls.board_bit = req_word[12];
   end

   assign req_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_valid && q_pop;
   assign q_entry   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry_in;
      end
   end

   `TDC_BWU_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
   `TDC_BWU_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + CNT_W'(1), "queue count did not advance on push")
   `TDC_BWU_ASSERT_IMPLIES(a_ptr_gap, clock, reset, count_ff == '0 || count_ff == CNT_W'(QUEUE_DEPTH), wr_ptr_ff == rd_ptr_ff, "queue pointers disagree with count")

endmodule

@@ design/tdc_bwu_back.sv @@
// ----------------------------------------------------------------------------
// tdc_bwu_back
// Parses queued words one per cycle while the output register is free or being emptied, and holds the result in it.
// ----------------------------------------------------------------------------
`include "tdc_block_word_unpacker_unit_assert.svh"

module tdc_bwu_back
   import tdc_bwu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  entry_type   q_entry,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_crate,
   output logic [4:0]  rsp_slot,
   output logic [5:0]  rsp_channel,
   output logic [11:0] rsp_value,
   output logic        rsp_count_ok
);

   typedef enum logic [1:0] {PH_TOP, PH_SKIP, PH_DATA, PH_TRAILER} phase_type;

   phase_type   phase_ff, phase_in, cur_phase;
   logic [9:0]  remaining_ff, remaining_in, cur_remaining;
   logic [7:0]  expected_ff, expected_in, cur_expected;
   logic [7:0]  seen_ff, seen_in, cur_seen;
   logic [7:0]  crate_ff, crate_in, cur_crate;
   logic [4:0]  slot_ff, slot_in, cur_slot;
   logic        ended_ff, ended_in, cur_ended;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff;
   logic [7:0]  rsp_crate_ff;
   logic [4:0]  rsp_slot_ff;
   logic [5:0]  rsp_channel_ff;
   logic [11:0] rsp_value_ff;
   logic        rsp_count_ok_ff;

   logic        res_valid;
   logic [1:0]  res_kind;
   logic [5:0]  res_channel;
   logic [11:0] res_value;
   logic        res_count_ok;
   logic        take;
   logic [31:0] w;

   // Advance only when the output register is free or being emptied
   assign take  = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign q_pop = take;
   assign w     = q_entry.word;

   always_comb begin
      // A new subevent clears the parser before the word is parsed
      if (q_entry.sub_start) begin
         cur_phase     = PH_TOP;
         cur_remaining = '0;
         cur_expected  = '0;
         cur_seen      = '0;
         cur_crate     = '0;
         cur_slot      = '0;
         cur_ended     = 1'b0;
      end else begin
         cur_phase     = phase_ff;
         cur_remaining = remaining_ff;
         cur_expected  = expected_ff;
         cur_seen      = seen_ff;
         cur_crate     = crate_ff;
         cur_slot      = slot_ff;
         cur_ended     = ended_ff;
      end

      phase_in     = cur_phase;
      remaining_in = cur_remaining;
      expected_in  = cur_expected;
      seen_in      = cur_seen;
      crate_in     = cur_crate;
      slot_in      = cur_slot;
      ended_in     = cur_ended;

      res_valid    = 1'b0;
      res_kind     = KIND_HIT;
      res_channel  = '0;
      res_value    = '0;
      res_count_ok = 1'b0;

      if (!cur_ended) begin
         unique case (cur_phase)
            PH_SKIP: begin
               remaining_in = cur_remaining - 10'd1;
               if (remaining_in == '0) begin
                  phase_in = PH_TOP;
               end
            end
            PH_DATA: begin
               if (q_entry.cls.is_zero) begin
                  ended_in     = 1'b1;
                  phase_in     = PH_TOP;
                  res_valid    = 1'b1;
                  res_kind     = KIND_NO_TRAILER;
                  res_count_ok = (cur_seen == cur_expected);
               end else begin
                  seen_in = cur_seen + 8'd1;
                  if (seen_in >= cur_expected) begin
                     phase_in = PH_TRAILER;
                  end
                  // Drop words from another slot
                  if (w[31:27] == cur_slot) begin
                     res_valid   = 1'b1;
                     res_kind    = KIND_HIT;
                     res_channel = w[21:16];
                     res_value   = (w[11:0] == VALUE_OVERFLOW) ? 12'd0 : w[11:0];
                  end
               end
            end
            PH_TRAILER: begin
               phase_in     = PH_TOP;
               res_valid    = 1'b1;
               res_count_ok = (cur_seen == cur_expected);
               if (q_entry.cls.is_zero) begin
                  ended_in = 1'b1;
               end
               if (q_entry.cls.wtype != WT_TRAILER) begin
                  res_kind = KIND_NO_TRAILER;
               end else if (w[7:0] != q_entry.trig_tag) begin
                  res_kind = KIND_TAG_ERR;
               end else begin
                  res_kind = KIND_OK;
               end
            end
            PH_TOP: begin
               if (q_entry.cls.is_zero) begin
                  ended_in = 1'b1;
               end else if (q_entry.cls.wtype == WT_BLOCK_HDR) begin
                  if (q_entry.cls.board_bit) begin
                     remaining_in = w[9:0];
                     if (w[9:0] != '0) begin
                        phase_in = PH_SKIP;
                     end
                  end
               end else if (q_entry.cls.wtype == WT_CONV_HDR) begin
                  expected_in = w[15:8];
                  crate_in    = w[23:16];
                  slot_in     = w[31:27];
                  seen_in     = '0;
                  phase_in    = (w[15:8] == '0) ? PH_TRAILER : PH_DATA;
               end
            end
            default: begin
               phase_in = PH_TOP;
            end
         endcase
      end

      rsp_valid_in = take ? res_valid : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TOP;
         remaining_ff <= '0;
         expected_ff  <= '0;
         seen_ff      <= '0;
         crate_ff     <= '0;
         slot_ff      <= '0;
         ended_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff     <= phase_in;
            remaining_ff <= remaining_in;
            expected_ff  <= expected_in;
            seen_ff      <= seen_in;
            crate_ff     <= crate_in;
            slot_ff      <= slot_in;
            ended_ff     <= ended_in;
         end
      end
      if (take && res_valid) begin
         rsp_kind_ff     <= res_kind;
         rsp_crate_ff    <= cur_crate;
         rsp_slot_ff     <= cur_slot;
         rsp_channel_ff  <= res_channel;
         rsp_value_ff    <= res_value;
         rsp_count_ok_ff <= res_count_ok;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_crate    = rsp_crate_ff;
   assign rsp_slot     = rsp_slot_ff;
   assign rsp_channel  = rsp_channel_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_count_ok = rsp_count_ok_ff;

   `TDC_BWU_ASSERT_IMPLIES(a_skip_nonzero, clock, reset, phase_ff == PH_SKIP, remaining_ff != '0, "skip phase with nothing left to skip")
   `TDC_BWU_ASSERT_IMPLIES(a_ended_top, clock, reset, ended_ff, phase_ff == PH_TOP, "closed subevent outside top level")
   `TDC_BWU_ASSERT_IMPLIES(a_hit_no_cok, clock, reset, rsp_valid_ff && rsp_kind_ff == KIND_HIT, !rsp_count_ok_ff, "hit result carries count flag")

endmodule

@@ design/tdc_block_word_unpacker_unit.sv @@
// ----------------------------------------------------------------------------
// tdc_block_word_unpacker_unit
// Unpacks converter-board readout words into hit and block status results.
// ----------------------------------------------------------------------------
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  word, trig_tag, sub_start
//   rsp_      out        rsp_valid/rsp_stall  kind, crate, slot, channel, value, count_ok
//
// One word per cycle sustained while the output is not stalled; the parser state updates as each word is taken.
// A request reaches its result through the queue, then the output register.
// The queue of QUEUE_DEPTH requests absorbs output stalls; req_stall is high
// only while it is full.
// Reset is synchronous and clears the queue, the parser and the output valid.
// ----------------------------------------------------------------------------
module tdc_block_word_unpacker_unit
   import tdc_bwu_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_word,
   input  logic [7:0]  req_trig_tag,
   input  logic        req_sub_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_crate,
   output logic [4:0]  rsp_slot,
   output logic [5:0]  rsp_channel,
   output logic [11:0] rsp_value,
   output logic        rsp_count_ok
);

   logic      q_valid;
   logic      q_pop;
   entry_type q_entry;

   tdc_bwu_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_word     (req_word),
      .req_trig_tag (req_trig_tag),
      .req_sub_start(req_sub_start),
      .q_valid      (q_valid),
      .q_entry      (q_entry),
      .q_pop        (q_pop)
   );

   tdc_bwu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_kind    (rsp_kind),
      .rsp_crate   (rsp_crate),
      .rsp_slot    (rsp_slot),
      .rsp_channel (rsp_channel),
      .rsp_value   (rsp_value),
      .rsp_count_ok(rsp_count_ok)
   );

endmodule

@@ verif/tdc_block_word_unpacker_unit_tb.sv @@
// ----------------------------------------------------------------------------
// tdc_block_word_unpacker_unit_tb
// Feeds readout word streams to the unpacker and compares each hit and block
// status with a parser model kept in the bench. Directed cases cover block
// headers, converter blocks, trailer faults, subevent ends and restarts. One
// case holds the output off for a long stretch. A long random stream of mostly
// well-formed blocks then runs with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tdc_block_word_unpacker_unit_tb;
   import tdc_bwu_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int RANDOM_WORDS = 1500;
   localparam int HOLD_CYCLES  = 400;

   typedef enum logic [1:0] {ST_SCAN, ST_SKIP, ST_DATA, ST_TRAILER} parse_state_type;
   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_style_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  crate;
      logic [4:0]  slot;
      logic [5:0]  channel;
      logic [11:0] value;
      logic        count_ok;
   } unit_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_word = '0;
   logic [7:0]  req_trig_tag = '0;
   logic        req_sub_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_crate;
   logic [4:0]  rsp_slot;
   logic [5:0]  rsp_channel;
   logic [11:0] rsp_value;
   logic        rsp_count_ok;

   // parser model state
   parse_state_type parse_state = ST_SCAN;
   logic [9:0]      skip_left = '0;
   logic [7:0]      block_size = '0;
   logic [7:0]      data_count = '0;
   logic [7:0]      cur_crate = '0;
   logic [4:0]      cur_slot = '0;
   logic            sub_closed = 1'b0;

   unit_result_type awaited_results[$];
   int              fail_count = 0;
   int              parsed_words = 0;
   int              cycle_count = 0;
   bit              pacing_on = 1'b0;
   int              burst_left = 0;
   stall_style_type stall_style = STALL_NONE;
   int              hold_request = 0;
   logic [7:0]      sub_tag = '0;
   logic            sub_first = 1'b0;

   tdc_block_word_unpacker_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_word     (req_word),
      .req_trig_tag (req_trig_tag),
      .req_sub_start(req_sub_start),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_kind     (rsp_kind),
      .rsp_crate    (rsp_crate),
      .rsp_slot     (rsp_slot),
      .rsp_channel  (rsp_channel),
      .rsp_value    (rsp_value),
      .rsp_count_ok (rsp_count_ok)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic void await_result(input logic [1:0] kind, input logic [5:0] channel,
                                        input logic [11:0] value, input logic count_ok);
      awaited_results.push_back(unit_result_type'{kind, cur_crate, cur_slot, channel, value,
                                                  count_ok});
   endfunction

   // Advance the parser model by one accepted word; return 0 if the word was ignored.
   function automatic bit unpack_word(input logic [31:0] w, input logic [7:0] tag,
                                      input logic start);
      logic [1:0] wtype;
      logic [1:0] kind;
      wtype = w[26:25];
      if (start) begin
         parse_state = ST_SCAN;
         skip_left   = '0;
         block_size  = '0;
         data_count  = '0;
         cur_crate   = '0;
         cur_slot    = '0;
         sub_closed  = 1'b0;
      end
      if (sub_closed)
         return 1'b0;
      case (parse_state)
         ST_SKIP: begin
            skip_left = skip_left - 10'd1;
            if (skip_left == '0)
               parse_state = ST_SCAN;
         end
         ST_DATA: begin
            if (w == '0) begin
               sub_closed  = 1'b1;
               parse_state = ST_SCAN;
               await_result(KIND_NO_TRAILER, '0, '0, data_count == block_size);
            end else begin
               data_count = data_count + 8'd1;
               if (data_count >= block_size)
                  parse_state = ST_TRAILER;
               // a foreign slot still counts toward the block size
               if (w[31:27] == cur_slot)
                  await_result(KIND_HIT, w[21:16],
                               (w[11:0] == VALUE_OVERFLOW) ? 12'h000 : w[11:0], 1'b0);
            end
         end
         ST_TRAILER: begin
            parse_state = ST_SCAN;
            if (w == '0)
               sub_closed = 1'b1;
            if (wtype != WT_TRAILER)
               kind = KIND_NO_TRAILER;
            else if (w[7:0] != tag)
               kind = KIND_TAG_ERR;
            else
               kind = KIND_OK;
            await_result(kind, '0, '0, data_count == block_size);
         end
         default: begin
            if (w == '0) begin
               sub_closed = 1'b1;
            end else if (wtype == WT_BLOCK_HDR) begin
               if (w[12]) begin
                  skip_left = w[9:0];
                  if (skip_left != '0)
                     parse_state = ST_SKIP;
               end
            end else if (wtype == WT_CONV_HDR) begin
               block_size  = w[15:8];
               cur_crate   = w[23:16];
               cur_slot    = w[31:27];
               data_count  = '0;
               parse_state = (block_size == '0) ? ST_TRAILER : ST_DATA;
            end
         end
      endcase
      return 1'b1;
   endfunction

   function automatic logic [31:0] block_header(input logic board, input logic [9:0] count);
      logic [31:0] w;
      w = $urandom;
      w[26:25] = WT_BLOCK_HDR;
      w[12]    = board;
      w[9:0]   = count;
      return w;
   endfunction

   function automatic logic [31:0] conv_header(input logic [4:0] slot, input logic [7:0] crate,
                                               input logic [7:0] size);
      logic [31:0] w;
      w = $urandom;
      w[31:27] = slot;
      w[26:25] = WT_CONV_HDR;
      w[23:16] = crate;
      w[15:8]  = size;
      return w;
   endfunction

   function automatic logic [31:0] hit_word(input logic [4:0] slot, input logic [5:0] channel,
                                            input logic [11:0] value);
      logic [31:0] w;
      w = $urandom;
      w[31:27] = slot;
      w[21:16] = channel;
      w[11:0]  = value;
      return w;
   endfunction

   function automatic logic [31:0] trailer_word(input logic [7:0] tag);
      logic [31:0] w;
      w = $urandom;
      w[26:25] = WT_TRAILER;
      w[7:0]   = tag;
      return w;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Offer one request and hold it until accepted.
   task automatic send_word(input logic [31:0] w, input logic [7:0] tag, input logic start);
      int gap;
      req_valid     <= 1'b1;
      req_word      <= w;
      req_trig_tag  <= tag;
      req_sub_start <= start;
      do @(posedge clock); while (req_stall);
      if (unpack_word(w, tag, start))
         parsed_words++;
      if (pacing_on) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 24);
            gap = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Send within the current subevent; now and then restart it mid-stream.
   task automatic feed_word(input logic [31:0] w);
      send_word(w, sub_tag, sub_first || ($urandom_range(0, 149) == 0));
      sub_first = 1'b0;
   endtask

   function automatic bit stream_done();
      return sub_closed && !sub_first;
   endfunction

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_results.size() != 0);
   endtask

   task automatic test_block_headers();
      send_word(block_header(1'b1, 10'd3), 8'h00, 1'b1);
      send_word($urandom, 8'h00, 1'b0);
      send_word(32'h0000_0000, 8'h00, 1'b0);
      send_word(32'hffff_ffff, 8'h00, 1'b0);
      send_word(block_header(1'b0, 10'h3ff), 8'h00, 1'b0);
      send_word(block_header(1'b1, 10'd0), 8'h00, 1'b0);
      send_word(32'hffff_ffff, 8'h00, 1'b0);
      send_word(trailer_word(8'h33), 8'h00, 1'b0);
      drain_results();
   endtask

   task automatic test_hits_and_trailers();
      send_word(conv_header(5'd31, 8'hff, 8'd5), 8'hff, 1'b0);
      send_word(hit_word(5'd31, 6'd63, VALUE_OVERFLOW), 8'hff, 1'b0);
      send_word(hit_word(5'd31, 6'd0, 12'hffe), 8'hff, 1'b0);
      send_word(hit_word(5'd30, 6'd5, 12'h123), 8'hff, 1'b0);
      send_word(hit_word(5'd31, 6'd1, 12'h000), 8'hff, 1'b0);
      send_word(hit_word(5'd31, 6'd2, 12'h800), 8'hff, 1'b0);
      send_word(trailer_word(8'hff), 8'hff, 1'b0);
      // empty block goes straight to the trailer, here with a bad tag
      send_word(conv_header(5'd0, 8'h00, 8'd0), 8'hff, 1'b0);
      send_word(trailer_word(8'h00), 8'hff, 1'b0);
      drain_results();
   endtask

   task automatic test_trailer_faults();
      send_word(conv_header(5'd7, 8'h81, 8'd1), 8'h5a, 1'b1);
      send_word(hit_word(5'd7, 6'd9, 12'h456), 8'h5a, 1'b0);
      send_word(conv_header(5'd8, 8'h82, 8'd1), 8'h5a, 1'b0);
      send_word(conv_header(5'd3, 8'h01, 8'd1), 8'h5a, 1'b0);
      send_word(hit_word(5'd3, 6'd4, 12'h0aa), 8'h5a, 1'b0);
      send_word(32'h0000_0000, 8'h5a, 1'b0);
      send_word(conv_header(5'd3, 8'h02, 8'd0), 8'h5a, 1'b0);
      drain_results();
   endtask

   task automatic test_subevent_end_and_restart();
      send_word(conv_header(5'd12, 8'h40, 8'd4), 8'ha5, 1'b1);
      send_word(hit_word(5'd12, 6'd10, 12'h321), 8'ha5, 1'b0);
      send_word(32'h0000_0000, 8'ha5, 1'b0);
      send_word(conv_header(5'd9, 8'h11, 8'd3), 8'ha5, 1'b1);
      send_word(hit_word(5'd9, 6'd11, 12'h654), 8'ha5, 1'b0);
      // restart drops the open block without a status
      send_word(conv_header(5'd9, 8'h12, 8'd1), 8'ha5, 1'b1);
      send_word(hit_word(5'd9, 6'd12, 12'h987), 8'ha5, 1'b0);
      send_word(trailer_word(8'ha5), 8'ha5, 1'b0);
      send_word(32'h0000_0000, 8'ha5, 1'b0);
      send_word(hit_word(5'd9, 6'd13, 12'h111), 8'ha5, 1'b0);
      drain_results();
   endtask

   task automatic test_backpressure();
      stall_style  = STALL_NONE;
      hold_request = HOLD_CYCLES;
      send_word(conv_header(5'd17, 8'h3c, 8'd24), 8'h77, 1'b1);
      for (int i = 0; i < 24; i++)
         send_word(hit_word(5'd17, 6'(i), 12'($urandom)), 8'h77, 1'b0);
      send_word(trailer_word(8'h77), 8'h77, 1'b0);
      drain_results();
   endtask

   task automatic random_subevent();
      int         blocks;
      int         pick;
      int         size;
      logic [4:0] slot;
      logic [4:0] word_slot;
      logic [7:0] crate;
      logic [11:0] value;
      sub_tag   = 8'($urandom);
      sub_first = 1'b1;
      blocks    = $urandom_range(1, 4);
      for (int b = 0; b < blocks && !stream_done(); b++) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            size = $urandom_range(0, 6);
            feed_word(block_header(1'b1, 10'(size)));
            repeat (size) feed_word(($urandom_range(0, 4) == 0) ? 32'h0 : $urandom);
         end else if (pick < 30) begin
            feed_word(block_header(1'b0, 10'($urandom)));
         end else if (pick < 38) begin
            feed_word($urandom);
         end
         if (stream_done())
            break;
         slot  = 5'($urandom);
         crate = 8'($urandom);
         size  = ($urandom_range(0, 79) == 0) ? $urandom_range(64, 255) : $urandom_range(0, 8);
         feed_word(conv_header(slot, crate, 8'(size)));
         for (int i = 0; i < size && !stream_done(); i++) begin
            word_slot = ($urandom_range(0, 15) == 0) ? 5'(slot + $urandom_range(1, 31)) : slot;
            case ($urandom_range(0, 7))
               0: value = VALUE_OVERFLOW;
               1: value = 12'h000;
               2: value = 12'hffe;
               default: value = 12'($urandom);
            endcase
            feed_word(($urandom_range(0, 299) == 0) ? 32'h0 :
                      hit_word(word_slot, 6'($urandom), value));
         end
         if (stream_done())
            break;
         pick = $urandom_range(0, 99);
         if (pick < 78)
            feed_word(trailer_word(sub_tag));
         else if (pick < 88)
            feed_word(trailer_word(8'(sub_tag ^ $urandom_range(1, 255))));
         else if (pick < 96)
            feed_word(conv_header(5'($urandom), 8'($urandom), 8'($urandom)));
         else
            feed_word(32'h0);
      end
      if (!stream_done()) begin
         if ($urandom_range(0, 9) < 6)
            feed_word(32'h0);
         if ($urandom_range(0, 4) == 0)
            feed_word($urandom);
      end
   endtask

   task automatic test_random_stream();
      parsed_words = 0;
      while (parsed_words < RANDOM_WORDS) begin
         stall_style = stall_style_type'($urandom_range(0, 3));
         pacing_on   = ($urandom_range(0, 3) != 0);
         random_subevent();
      end
      drain_results();
   endtask

   // Receiver: a long hold when asked, else the current stall pattern.
   initial begin : receiver
      int hold_left;
      int tick;
      hold_left = 0;
      tick      = 0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         tick++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_style)
               STALL_NONE:     rsp_stall <= 1'b0;
               STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_PERIODIC: rsp_stall <= ((tick % 7) < 3);
               default:        rsp_stall <= ($urandom_range(0, 9) < 7);
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_results
      unit_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            $error("result with none awaited: kind %0d channel %0d value 0x%0h",
                   rsp_kind, rsp_channel, rsp_value);
            fail_count++;
         end else begin
            want = awaited_results.pop_front();
            check_field("kind", 32'(want.kind), 32'(rsp_kind));
            check_field("crate", 32'(want.crate), 32'(rsp_crate));
            check_field("slot", 32'(want.slot), 32'(rsp_slot));
            check_field("channel", 32'(want.channel), 32'(rsp_channel));
            check_field("value", 32'(want.value), 32'(rsp_value));
            check_field("count_ok", 32'(want.count_ok), 32'(rsp_count_ok));
         end
      end
   end

   initial begin : run
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      stall_style = STALL_LIGHT;
      test_block_headers();
      test_hits_and_trailers();
      test_trailer_faults();
      test_subevent_end_and_restart();
      test_backpressure();
      test_random_stream();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/tdc_bwu_pkg.sv
design/tdc_bwu_front.sv
design/tdc_bwu_back.sv
design/tdc_block_word_unpacker_unit.sv
verif/tdc_block_word_unpacker_unit_tb.sv
